// ===== design/prts_pkg.sv =====
package prts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TICK_W    = 32;
  localparam int PRIO_W    = 8;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_DELAY  = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_STARTED = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic              create;
    logic              block;
    logic              wake;
    logic [IDX_W-1:0]  idx;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] wake_val;
    logic [TICK_W-1:0] tick;
  } cell_cmd_t;

  // running best candidate handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]  idx;
  } carry_t;

endpackage

// ===== design/priority_round_robin_task_scheduler.sv =====
// priority scheduler over a chain of task cells, one cell per table entry
// create and start: the execute state, then the done state, which writes the result word
// tick and delay: the execute state, then the scan state (skipped when nothing can be scheduled),
//   in which the best candidate walks through the cell chain one cell per cycle, then the done state
// one item at a time: a new item is taken only back in idle,
//   once the result sits in the output register
// rst (synchronous, active high) clears the blocked bits, count, current, tick and started
module priority_round_robin_task_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [prts_pkg::PRIO_W-1:0] priority_req,
  input  logic [prts_pkg::TICK_W-1:0] delay_ticks,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [prts_pkg::IDX_W-1:0]  task_index,
  output logic                        switch_needed,
  output logic [1:0]                  status,
  output logic [prts_pkg::TICK_W-1:0] tick_now
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t                      state;
  logic [1:0]                  op_r;
  logic [prts_pkg::PRIO_W-1:0] prio_r;
  logic [prts_pkg::TICK_W-1:0] delay_r;
  logic [prts_pkg::TICK_W-1:0] tick_counter;
  logic [prts_pkg::CNT_W-1:0]  task_count;
  logic [prts_pkg::IDX_W-1:0]  current_index;
  logic                        started;
  logic [prts_pkg::CNT_W-1:0]  scan_cnt;
  // pending result word
  logic [prts_pkg::IDX_W-1:0]  res_idx;
  logic                        res_sw;
  logic [1:0]                  res_st;

  prts_pkg::cell_cmd_t cmd;
  prts_pkg::carry_t    best;
  logic                no_sched;
  logic [prts_pkg::IDX_W-1:0] pick;

  assign in_stall = (state != S_IDLE);
  assign no_sched = !started || task_count == '0 || {1'b0, current_index} >= task_count;
  // nothing ready: current task stays
  assign pick     = best.found ? best.idx : current_index;

  // cell commands issue only in the execute cycle
  always_comb begin
    cmd          = '0;
    cmd.idx      = current_index;
    cmd.prio     = prio_r;
    cmd.tick     = tick_counter;
    cmd.wake_val = tick_counter + delay_r;
    if (state == S_EXEC) begin
      case (op_r)
        prts_pkg::OP_CREATE: begin
          cmd.create = task_count < prts_pkg::CNT_W'(prts_pkg::MAX_TASKS);
          cmd.idx    = task_count[prts_pkg::IDX_W-1:0];
        end
        prts_pkg::OP_TICK:   cmd.wake  = !no_sched;
        prts_pkg::OP_DELAY:  cmd.block = !no_sched;
        default:             cmd.wake  = 1'b0;
      endcase
    end
  end

  prts_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .cur  (current_index),
    .count(task_count),
    .best (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_counter  <= '0;
      task_count    <= '0;
      current_index <= '0;
      started       <= 1'b0;
      out_valid     <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op;
            prio_r  <= priority_req;
            delay_r <= delay_ticks;
            if (op == prts_pkg::OP_TICK) begin
              tick_counter <= tick_counter + 1'b1;
            end
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          scan_cnt <= '0;
          state    <= S_DONE;
          unique case (op_r)
            prts_pkg::OP_CREATE: begin
              if (task_count >= prts_pkg::CNT_W'(prts_pkg::MAX_TASKS)) begin
                res_idx <= '0;
                res_sw  <= 1'b0;
                res_st  <= prts_pkg::ST_FULL;
              end else begin
                res_idx    <= task_count[prts_pkg::IDX_W-1:0];
                res_sw     <= 1'b0;
                res_st     <= prts_pkg::ST_OK;
                task_count <= task_count + 1'b1;
              end
            end
            prts_pkg::OP_START: begin
              res_idx <= '0;
              if (task_count == '0) begin
                res_sw <= 1'b0;
                res_st <= prts_pkg::ST_NOT_STARTED;
              end else begin
                res_sw        <= started && current_index != '0;
                res_st        <= prts_pkg::ST_OK;
                current_index <= '0;
                started       <= 1'b1;
              end
            end
            default: begin
              // tick or delay
              res_idx <= current_index;
              res_sw  <= 1'b0;
              res_st  <= prts_pkg::ST_NOT_STARTED;
              if (!no_sched) begin
                state <= S_SCAN;
              end
            end
          endcase
        end
        S_SCAN: begin
          // let the candidate ripple through every cell
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == prts_pkg::CNT_W'(prts_pkg::MAX_TASKS)) begin
            res_idx       <= pick;
            res_sw        <= pick != current_index;
            res_st        <= prts_pkg::ST_OK;
            current_index <= pick;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            task_index    <= res_idx;
            switch_needed <= res_sw;
            status        <= res_st;
            tick_now      <= tick_counter;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/prts_cell.sv =====
module prts_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [prts_pkg::IDX_W-1:0]      my_idx,
  input  prts_pkg::cell_cmd_t             cmd,
  input  logic [prts_pkg::IDX_W-1:0]      cur,
  input  logic [prts_pkg::CNT_W-1:0]      count,
  input  prts_pkg::carry_t                carry_in,
  output prts_pkg::carry_t                carry_out
);

  logic [prts_pkg::PRIO_W-1:0] prio;
  logic [prts_pkg::TICK_W-1:0] wake;
  logic                        blocked;
  logic                        active;
  logic                        take;

  assign active = {1'b0, my_idx} < count;

  // ties go to the first entry after the current one in ring order
  always_comb begin
    take = 1'b0;
    if (active && !blocked) begin
      if (!carry_in.found || prio > carry_in.prio) begin
        take = 1'b1;
      end else if (prio == carry_in.prio && carry_in.idx <= cur && my_idx > cur) begin
        take = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked         <= 1'b0;
      carry_out.found <= 1'b0;
    end else begin
      if (cmd.create && cmd.idx == my_idx) begin
        blocked <= 1'b0;
      end else if (cmd.block && cmd.idx == my_idx) begin
        blocked <= 1'b1;
      end else if (cmd.wake && blocked && cmd.tick >= wake) begin
        blocked <= 1'b0;
      end
      carry_out.found <= carry_in.found | take;
    end
    if (cmd.create && cmd.idx == my_idx) begin
      prio <= cmd.prio;
    end
    if (cmd.block && cmd.idx == my_idx) begin
      wake <= cmd.wake_val;
    end
    carry_out.prio <= take ? prio : carry_in.prio;
    carry_out.idx  <= take ? my_idx : carry_in.idx;
  end

endmodule

// ===== design/prts_chain.sv =====
module prts_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  prts_pkg::cell_cmd_t        cmd,
  input  logic [prts_pkg::IDX_W-1:0] cur,
  input  logic [prts_pkg::CNT_W-1:0] count,
  output prts_pkg::carry_t           best
);

  prts_pkg::carry_t carry [prts_pkg::MAX_TASKS+1];

  assign carry[0] = '0;

  for (genvar g = 0; g < prts_pkg::MAX_TASKS; g++) begin : g_cell
    prts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_idx   (prts_pkg::IDX_W'(g)),
      .cmd      (cmd),
      .cur      (cur),
      .count    (count),
      .carry_in (carry[g]),
      .carry_out(carry[g+1])
    );
  end

  assign best = carry[prts_pkg::MAX_TASKS];

endmodule

// ===== design/prts_checker.sv =====
module prts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [prts_pkg::IDX_W-1:0]  task_index,
  input logic [1:0]                  status
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(task_index) && $stable(status))
    else $error("result word changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == prts_pkg::ST_FULL |-> task_index == '0)
    else $error("table full word carries an index");

endmodule

bind priority_round_robin_task_scheduler prts_checker u_prts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .task_index(task_index),
  .status    (status)
);
